FILE: rtl/core/u8dec_pkg.sv
// Shared types and constants for the byte-serial UTF-8 decoder.
// No dependencies; used by every module under rtl/core.
package u8dec_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CP_W     = 21;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEFT_W   = 2;
  localparam int unsigned LEN_W    = 3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_ENC   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_UNI   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TRUNCATED = 2'd3;

  // Sequence lengths selected by the lead byte
  localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
  localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
  localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

  // Smallest legal value per sequence length, and the scalar limits
  localparam logic [CP_W-1:0] MIN_TWO    = 21'h00080;
  localparam logic [CP_W-1:0] MIN_THREE  = 21'h00800;
  localparam logic [CP_W-1:0] MIN_FOUR   = 21'h10000;
  localparam logic [CP_W-1:0] SURR_LO    = 21'h0D800;
  localparam logic [CP_W-1:0] SURR_HI    = 21'h0DFFF;
  localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;

  // One input beat as held in the input register
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } item_t;

  // Handshake between input register and decode stage
  typedef struct packed {
    logic valid;
  } stage_ctl_t;

  // Surrogate or beyond the Unicode range
  function automatic logic is_nonscalar(input logic [CP_W-1:0] cp);
    return ((cp >= SURR_LO) && (cp <= SURR_HI)) || (cp > CP_MAX);
  endfunction

endpackage

FILE: rtl/core/utf8_stream_decoder_top.sv
// Byte-serial UTF-8 decoder: accepts one byte and an end-of-buffer flag per
// beat and returns at most one code point with status per byte. One byte is
// accepted every cycle while the receiver keeps up. An accepted byte is held
// in the input register and decoded from there into the result register,
// which presents any result it yields. A result held by a stalled receiver
// stops the input register and, while that register holds a byte, drops
// in_ready in the same cycle. Status: 0 ok, 1 bad encoding (invalid lead or
// overlong), 2 surrogate or beyond U+10FFFF, 3 buffer ended mid-sequence.
// Depends on u8dec_pkg, u8dec_in_reg and u8dec_core.
module utf8_stream_decoder_top
  import u8dec_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [BYTE_W-1:0]   data_byte,
  input  logic                last_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CP_W-1:0]     scalar_value,
  output logic [STATUS_W-1:0] status
);

  stage_ctl_t ctl;
  item_t      item;
  logic       advance;

  u8dec_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .advance   (advance),
    .ctl       (ctl),
    .item      (item)
  );

  u8dec_core u_core (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .item         (item),
    .advance      (advance),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .scalar_value (scalar_value),
    .status       (status)
  );

endmodule

FILE: rtl/core/u8dec_in_reg.sv
// Input register of the UTF-8 decoder: captures one beat per cycle while in_ready is high.
// Depends on u8dec_pkg.
module u8dec_in_reg
  import u8dec_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              last_byte,
  input  logic              advance,
  output stage_ctl_t        ctl,
  output item_t             item
);

  logic  valid_q;
  item_t item_q;

  // Accept a new beat when empty or when the held beat moves on this cycle
  assign in_ready = !valid_q || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ready) begin
      valid_q <= in_valid;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q.data_byte <= data_byte;
      item_q.last_byte <= last_byte;
    end
  end

  assign ctl.valid   = valid_q;
  assign item        = item_q;

endmodule

FILE: rtl/core/u8dec_core.sv
// Decode stage: running sequence state, validity checks and result register.
// Depends on u8dec_pkg.
module u8dec_core
  import u8dec_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  stage_ctl_t          ctl,
  input  item_t               item,
  output logic                advance,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CP_W-1:0]     scalar_value,
  output logic [STATUS_W-1:0] status
);

  logic [CP_W-1:0]   partial_value;
  logic [LEFT_W-1:0] bytes_left;
  logic [LEN_W-1:0]  sequence_length;
  logic              res_valid;
  logic [CP_W-1:0]   res_cp;
  logic [STATUS_W-1:0] res_status;

  logic [CP_W-1:0]   partial_value_next;
  logic [LEFT_W-1:0] bytes_left_next;
  logic [LEN_W-1:0]  sequence_length_next;
  logic              emit;
  logic [CP_W-1:0]   emit_cp;
  logic [STATUS_W-1:0] emit_status;
  logic [CP_W-1:0]   merged;
  logic [LEFT_W-1:0] left_dec;
  logic [BYTE_W-1:0] b;
  logic              take;

  // The held beat moves on whenever the result register is free or draining
  assign advance = !res_valid || out_ready;
  assign take    = ctl.valid && advance;

  assign b        = item.data_byte;
  assign merged   = {partial_value[CP_W-7:0], b[5:0]};
  assign left_dec = bytes_left - LEFT_W'(1);

  // Decode one byte against the running state
  always_comb begin
    partial_value_next   = partial_value;
    bytes_left_next      = bytes_left;
    sequence_length_next = sequence_length;
    emit        = 1'b0;
    emit_cp     = '0;
    emit_status = ST_OK;
    if (bytes_left == '0) begin
      if (!b[7]) begin
        emit    = 1'b1;
        emit_cp = CP_W'(b[6:0]);
      end else if (b[7:5] == 3'b110) begin
        partial_value_next   = CP_W'(b[4:0]);
        bytes_left_next      = LEFT_W'(1);
        sequence_length_next = LEN_TWO;
      end else if (b[7:4] == 4'b1110) begin
        partial_value_next   = CP_W'(b[3:0]);
        bytes_left_next      = LEFT_W'(2);
        sequence_length_next = LEN_THREE;
      end else if (b[7:3] == 5'b11110) begin
        partial_value_next   = CP_W'(b[2:0]);
        bytes_left_next      = LEFT_W'(3);
        sequence_length_next = LEN_FOUR;
      end else begin
        emit        = 1'b1;
        emit_status = ST_BAD_ENC;
      end
      if (!emit && item.last_byte) begin
        emit        = 1'b1;
        emit_status = ST_TRUNCATED;
      end
    end else if (left_dec != '0) begin
      // Middle byte: shift in payload bits, or report a cut-off buffer
      partial_value_next = merged;
      bytes_left_next    = left_dec;
      if (item.last_byte) begin
        emit        = 1'b1;
        emit_status = ST_TRUNCATED;
      end
    end else begin
      // Final byte: overlong check first, then reserved range
      emit    = 1'b1;
      emit_cp = merged;
      case (sequence_length)
        LEN_TWO: begin
          if (merged < MIN_TWO) emit_status = ST_BAD_ENC;
        end
        LEN_THREE: begin
          if (merged < MIN_THREE)     emit_status = ST_BAD_ENC;
          else if (is_nonscalar(merged)) emit_status = ST_BAD_UNI;
        end
        LEN_FOUR: begin
          if (merged < MIN_FOUR)      emit_status = ST_BAD_ENC;
          else if (is_nonscalar(merged)) emit_status = ST_BAD_UNI;
        end
        default: begin
          emit_status = ST_OK;
        end
      endcase
    end
    if (emit) begin
      // Every result returns the decoder to its start state
      partial_value_next   = '0;
      bytes_left_next      = '0;
      sequence_length_next = LEN_NONE;
      if (emit_status != ST_OK) emit_cp = '0;
    end
  end

  // Advance the sequence state on each consumed beat
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value   <= '0;
      bytes_left      <= '0;
      sequence_length <= LEN_NONE;
    end else if (take) begin
      partial_value   <= partial_value_next;
      bytes_left      <= bytes_left_next;
      sequence_length <= sequence_length_next;
    end
  end

  // Result register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= take && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      res_cp     <= emit_cp;
      res_status <= emit_status;
    end
  end

  assign out_valid    = res_valid;
  assign scalar_value = res_cp;
  assign status       = res_status;

endmodule

FILE: sim/utf8_stream_decoder_top_tb.sv
// Self-checking testbench for utf8_stream_decoder_top: directed byte sequences,
// then random streams under four idle/stall mixes, checked against a local decoder.
// Depends on u8dec_pkg and the RTL under rtl/core.
module utf8_stream_decoder_top_tb;
  import u8dec_pkg::*;

  typedef struct {
    logic [CP_W-1:0]     cp;
    logic [STATUS_W-1:0] st;
  } decoded_t;

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  logic [BYTE_W-1:0]   data_byte  = '0;
  logic                last_byte  = 1'b0;
  logic                out_valid;
  logic                out_ready  = 1'b0;
  logic [CP_W-1:0]     scalar_value;
  logic [STATUS_W-1:0] status;

  // Decoder state as the testbench tracks it
  logic [CP_W-1:0]     acc_value = '0;
  logic [LEFT_W-1:0]   cont_left = '0;
  logic [LEN_W-1:0]    seq_len   = LEN_NONE;

  decoded_t pending_results[$];
  decoded_t head_result;
  int       mismatch_count = 0;
  int       send_idle_pct  = 0;
  int       recv_stall_pct = 0;

  utf8_stream_decoder_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .scalar_value (scalar_value),
    .status       (status)
  );

  always #5 clk = ~clk;

  // Queue one decoded result and return to the start state
  task automatic push_result(input logic [CP_W-1:0] cp, input logic [STATUS_W-1:0] st);
    decoded_t r;
    r.cp = (st == ST_OK) ? cp : '0;
    r.st = st;
    pending_results.push_back(r);
    acc_value = '0;
    cont_left = '0;
    seq_len   = LEN_NONE;
  endtask

  // Advance the tracked decoder by one accepted byte
  task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic is_last);
    logic [CP_W-1:0] cp;
    if (cont_left == 0) begin
      if (b[7] == 1'b0) begin
        push_result({14'd0, b[6:0]}, ST_OK);
        return;
      end
      if ((b & 8'he0) == 8'hc0) begin
        acc_value = {16'd0, b[4:0]};
        cont_left = 2'd1;
        seq_len   = LEN_TWO;
      end else if ((b & 8'hf0) == 8'he0) begin
        acc_value = {17'd0, b[3:0]};
        cont_left = 2'd2;
        seq_len   = LEN_THREE;
      end else if ((b & 8'hf8) == 8'hf0) begin
        acc_value = {18'd0, b[2:0]};
        cont_left = 2'd3;
        seq_len   = LEN_FOUR;
      end else begin
        push_result('0, ST_BAD_ENC);
        return;
      end
      if (is_last) push_result('0, ST_TRUNCATED);
      return;
    end

    // Shift in six payload bits; the continuation prefix is ignored
    acc_value = {acc_value[CP_W-7:0], b[5:0]};
    cont_left = cont_left - 2'd1;
    if (cont_left != 0) begin
      if (is_last) push_result('0, ST_TRUNCATED);
      return;
    end

    cp = acc_value;
    case (seq_len)
      LEN_TWO: begin
        if (cp < MIN_TWO) begin
          push_result('0, ST_BAD_ENC);
          return;
        end
      end
      LEN_THREE, LEN_FOUR: begin
        if (cp < ((seq_len == LEN_THREE) ? MIN_THREE : MIN_FOUR)) begin
          push_result('0, ST_BAD_ENC);
          return;
        end
        if ((cp >= SURR_LO && cp <= SURR_HI) || cp > CP_MAX) begin
          push_result('0, ST_BAD_UNI);
          return;
        end
      end
      default: ;
    endcase
    push_result(cp, ST_OK);
  endtask

  // Drive one beat from a falling edge and hold it until accepted
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic is_last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_byte(b, is_last);
    @(negedge clk);
  endtask

  // Receiver stalls at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: scalar_value=%h status=%0d",
                   scalar_value, status);
      end else begin
        head_result = pending_results.pop_front();
        if (scalar_value !== head_result.cp || status !== head_result.st) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            if (scalar_value !== head_result.cp)
              $display("scalar_value mismatch: expected %h, got %h",
                       head_result.cp, scalar_value);
            if (status !== head_result.st)
              $display("status mismatch: expected %0d, got %0d", head_result.st, status);
          end
        end
      end
    end
  end

  // Single bytes at the extremes and leads that can never start a sequence
  task automatic test_single_and_bad_leads();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7f, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'hff, 1'b0);
  endtask

  // Two- and three-byte encodings of values that fit a shorter form
  task automatic test_overlong_forms();
    send_byte(8'hc1, 1'b0);
    send_byte(8'hbf, 1'b0);
    send_byte(8'he0, 1'b0);
    send_byte(8'h9f, 1'b0);
    send_byte(8'hbf, 1'b0);
  endtask

  // Largest two-byte value, a surrogate, and both sides of U+10FFFF
  task automatic test_range_limits();
    send_byte(8'hdf, 1'b0);
    send_byte(8'hbf, 1'b0);
    send_byte(8'hed, 1'b0);
    send_byte(8'ha0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hf4, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hf4, 1'b0);
    send_byte(8'h8f, 1'b0);
    send_byte(8'hbf, 1'b0);
    send_byte(8'hbf, 1'b0);
  endtask

  // Buffer ends on a lead byte, then on a middle byte
  task automatic test_truncated_buffers();
    send_byte(8'hc3, 1'b1);
    send_byte(8'he2, 1'b0);
    send_byte(8'h82, 1'b1);
  endtask

  // Mostly well-formed sequences with random payload, some noise bytes
  task automatic test_random_stream(input int n_bytes, input int idle_pct, input int stall_pct);
    int          sent;
    int          seq_bytes;
    logic [7:0]  lead;
    logic        is_last;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(99) < 15) begin
        send_byte(8'($urandom_range(255)), $urandom_range(99) < 10);
        sent++;
      end else begin
        seq_bytes = $urandom_range(4, 1);
        case (seq_bytes)
          1:       lead = {1'b0, 7'($urandom_range(127))};
          2:       lead = {3'b110, 5'($urandom_range(31))};
          3:       lead = {4'b1110, 4'($urandom_range(15))};
          default: lead = {5'b11110, 3'($urandom_range(7))};
        endcase
        // Drop the buffer end onto the sequence now and then
        is_last = (seq_bytes == 1) ? ($urandom_range(99) < 20) : ($urandom_range(99) < 4);
        send_byte(lead, is_last);
        sent++;
        if (!is_last) begin
          for (int i = 1; i < seq_bytes; i++) begin
            is_last = (i == seq_bytes - 1) ? ($urandom_range(99) < 20)
                                           : ($urandom_range(99) < 4);
            if ($urandom_range(99) < 90)
              send_byte({2'b10, 6'($urandom_range(63))}, is_last);
            else
              send_byte(8'($urandom_range(255)), is_last);
            sent++;
            if (is_last) break;
          end
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_single_and_bad_leads();
    test_overlong_forms();
    test_range_limits();
    test_truncated_buffers();

    test_random_stream(260, 0, 0);
    test_random_stream(260, 65, 0);
    test_random_stream(260, 0, 65);
    test_random_stream(260, 12, 12);

    // Drain outstanding results, then allow the pipeline to settle
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stop a hung run
  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: utf8_stream_decoder_top.f
rtl/core/u8dec_pkg.sv
rtl/core/u8dec_in_reg.sv
rtl/core/u8dec_core.sv
rtl/core/utf8_stream_decoder_top.sv
sim/utf8_stream_decoder_top_tb.sv
